// ===== hw/rtl/iac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_pkg
// Shared types and constants for the intrusion alarm controller: mode and
// command codes, alert source codes, register indexes and the item records.
// ----------------------------------------------------------------------------
package iac_pkg;

   // Operating mode
   typedef enum logic [1:0] {
      MODE_DISARMED = 2'd0,
      MODE_ARMED    = 2'd1,
      MODE_ALARM    = 2'd2
   } mode_type;

   // Remote command
   typedef enum logic [1:0] {
      FUNC_NONE   = 2'd0,
      FUNC_ARM    = 2'd1,
      FUNC_DISARM = 2'd2,
      FUNC_STATUS = 2'd3
   } func_type;

   // Alert source codes
   localparam logic [2:0] SRC_MOTION_A = 3'd0;
   localparam logic [2:0] SRC_MOTION_B = 3'd1;
   localparam logic [2:0] SRC_DOOR     = 3'd2;
   localparam logic [2:0] SRC_WINDOW   = 3'd3;
   localparam logic [2:0] SRC_SHOCK    = 3'd4;
   localparam logic [2:0] SRC_TAMPER   = 3'd5;

   // Register indexes
   localparam logic [1:0] CSR_ENTRY_DELAY = 2'd0;
   localparam logic [1:0] CSR_MOTION_HOLD = 2'd1;
   localparam logic [1:0] CSR_SHOCK_HOLD  = 2'd2;
   localparam logic [1:0] CSR_DEBOUNCE    = 2'd3;

   // Field widths
   localparam int DELAY_W   = 8;
   localparam int HOLD_W    = 11;
   localparam int COUNT_W   = 8;
   localparam int ELAPSED_W = 18;
   localparam int CSR_W     = 11;

   // Register reset values
   localparam logic [7:0]  ENTRY_DELAY_RST = 8'd30;
   localparam logic [10:0] MOTION_HOLD_RST = 11'd1000;
   localparam logic [10:0] SHOCK_HOLD_RST  = 11'd500;
   localparam logic [7:0]  DEBOUNCE_RST    = 8'd50;

   // Saturation limits
   localparam logic [10:0] AGE_MAX     = 11'h7FF;
   localparam logic [7:0]  COUNT_MAX   = 8'hFF;
   localparam logic [17:0] ELAPSED_MAX = 18'h3FFFF;

   // One tick as taken from the input channel
   typedef struct packed {
      logic     motion_a_raw;
      logic     motion_b_raw;
      logic     door_raw;
      logic     window_raw;
      logic     shock_raw;
      logic     tamper_raw;
      func_type func;
   } item_type;

   // One bit per scanned sensor, in scan priority order
   typedef struct packed {
      logic motion_a;
      logic motion_b;
      logic door;
      logic window;
      logic shock;
   } sensor_vec_type;

   // One result
   typedef struct packed {
      mode_type   mode;
      logic       siren_on;
      logic       delay_blink;
      logic       alert_valid;
      logic [2:0] alert_source;
      logic       reply_valid;
      logic       reply_armed;
   } result_type;

endpackage

// ===== hw/rtl/iac_edge_qual.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_edge_qual
// Rising-edge qualifier with minimum hold, used for motion and shock inputs.
// ----------------------------------------------------------------------------
module iac_edge_qual
   import iac_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              enable,
   input  logic              raw,
   input  logic [HOLD_W-1:0] hold,
   output logic              fire
);

   logic              level_ff, level_in;
   logic [HOLD_W-1:0] age_ff, age_in;
   logic [HOLD_W-1:0] age_inc;

   // Age advances every tick, saturating
   assign age_inc = (age_ff == AGE_MAX) ? age_ff : age_ff + 1'b1;

   // Event: rising raw level while qualifier low
   assign fire = raw && !level_ff;

   always_comb begin
      level_in = level_ff;
      age_in   = age_inc;
      if (enable) begin
         if (fire) begin
            level_in = 1'b1;
            age_in   = '0;
         end else if (!raw && level_ff && (age_inc > hold)) begin
            level_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         age_ff   <= '0;
      end else if (step) begin
         level_ff <= level_in;
         age_ff   <= age_in;
      end
   end

endmodule

// ===== hw/rtl/iac_contact_qual.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_contact_qual
// Contact debouncer: a level change is accepted after it persists.
// ----------------------------------------------------------------------------
module iac_contact_qual
   import iac_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               enable,
   input  logic               raw,
   input  logic [COUNT_W-1:0] debounce,
   output logic               fire
);

   logic               level_ff, level_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_inc;
   logic               differ;

   assign differ    = raw != level_ff;
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   // A debounce of zero behaves as one since count_inc is at least one
   assign fire      = differ && (count_inc >= debounce);

   always_comb begin
      level_in = level_ff;
      count_in = count_ff;
      if (enable) begin
         if (fire) begin
            level_in = raw;
            count_in = '0;
         end else if (differ) begin
            count_in = count_inc;
         end else begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         count_ff <= '0;
      end else if (step) begin
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/iac_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_ctrl
// Mode, entry-delay timer, tamper tracking, sensor scan priority and remote
// command handling. Produces one result per tick.
// ----------------------------------------------------------------------------
module iac_ctrl
   import iac_pkg::*;
#(
   parameter int LIMIT_W = 18
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  item_type           item,
   input  logic [LIMIT_W-1:0] limit,
   input  sensor_vec_type     fire,
   output sensor_vec_type     scan_en,
   output result_type         result
);

   mode_type               mode_ff, mode_in;
   logic                   pending_ff, pending_in;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in;
   logic                   siren_ff, siren_in;
   logic                   tamper_ff;
   logic [ELAPSED_W-1:0]   elapsed_inc;
   logic                   tamper_chg;
   logic                   scan;
   logic                   hit;

   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign tamper_chg  = item.tamper_raw != tamper_ff;

   // Scan enable chain: a sensor is looked at only if no earlier one fired
   always_comb begin
      scan             = (tamper_chg ? MODE_ALARM : mode_ff) == MODE_ARMED && !pending_ff;
      scan_en.motion_a = scan;
      scan_en.motion_b = scan_en.motion_a && !fire.motion_a;
      scan_en.door     = scan_en.motion_b && !fire.motion_b;
      scan_en.window   = scan_en.door && !fire.door;
      scan_en.shock    = scan_en.window && !fire.window;
      hit = scan && (fire.motion_a || fire.motion_b || fire.door || fire.window
                     || fire.shock);
   end

   // Tick update
   always_comb begin
      mode_in    = mode_ff;
      pending_in = pending_ff;
      elapsed_in = elapsed_inc;
      siren_in   = siren_ff;
      result     = '0;

      // Tamper change forces alarm
      if (tamper_chg) begin
         pending_in          = 1'b1;
         elapsed_in          = '0;
         mode_in             = MODE_ALARM;
         siren_in            = 1'b1;
         result.alert_valid  = 1'b1;
         result.alert_source = SRC_TAMPER;
      end

      // Intrusion from the scan
      if (hit) begin
         elapsed_in         = '0;
         pending_in         = 1'b1;
         result.alert_valid = 1'b1;
         if (fire.motion_a)      result.alert_source = SRC_MOTION_A;
         else if (fire.motion_b) result.alert_source = SRC_MOTION_B;
         else if (fire.door)     result.alert_source = SRC_DOOR;
         else if (fire.window)   result.alert_source = SRC_WINDOW;
         else                    result.alert_source = SRC_SHOCK;
      end

      // Entry delay
      if (pending_in && mode_in == MODE_ARMED) begin
         if (elapsed_in >= ELAPSED_W'(limit)) begin
            mode_in  = MODE_ALARM;
            siren_in = 1'b1;
         end else begin
            result.delay_blink = 1'b1;
         end
      end

      // Remote command
      case (item.func)
         FUNC_NONE: begin
         end
         FUNC_ARM: begin
            mode_in = MODE_ARMED;
         end
         FUNC_DISARM: begin
            mode_in    = MODE_DISARMED;
            pending_in = 1'b0;
            siren_in   = 1'b0;
         end
         FUNC_STATUS: begin
            result.reply_valid = 1'b1;
            result.reply_armed = mode_in == MODE_ARMED;
         end
         default: begin
         end
      endcase

      result.mode     = mode_in;
      result.siren_on = siren_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_DISARMED;
         pending_ff <= 1'b0;
         elapsed_ff <= '0;
         siren_ff   <= 1'b0;
         tamper_ff  <= 1'b0;
      end else if (step) begin
         mode_ff    <= mode_in;
         pending_ff <= pending_in;
         elapsed_ff <= elapsed_in;
         siren_ff   <= siren_in;
         tamper_ff  <= item.tamper_raw;
      end
   end

endmodule

// ===== hw/rtl/intrusion_alarm_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intrusion_alarm_controller_top
// Alarm controller: one millisecond tick in, one status result out.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one tick: six raw sensor levels and a remote command.
//    A transfer happens when req_valid and req_ready are both high.
//  - rsp_* returns one result per tick, in order, on the same handshake.
//  - csr_* writes one register (index 0 entry delay, 1 motion hold,
//    2 shock hold, 3 contact debounce); csr_ready is always high. Write only
//    while no tick is in flight.
//  - A tick is captured in an input register, then the whole state update
//    runs combinationally into the result register: rsp_valid rises once
//    the result register is loaded after the input register. One tick per
//    cycle is sustained while rsp_ready is high; the limit is the update loop.
//  - Reset clears mode to disarmed, all timers and qualifiers, and loads the
//    register defaults (30 s, 1000, 500, 50).
//  - If the receiver stalls, the result register holds, the captured tick
//    waits, and req_ready drops until rsp_ready returns.
// ----------------------------------------------------------------------------
module intrusion_alarm_controller_top
   import iac_pkg::*;
#(
   parameter int TICKS_PER_SECOND = 1000
) (
   input  logic             clock,
   input  logic             reset,
   // Tick input
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_motion_a_raw,
   input  logic             req_motion_b_raw,
   input  logic             req_door_raw,
   input  logic             req_window_raw,
   input  logic             req_shock_raw,
   input  logic             req_tamper_raw,
   input  logic [1:0]       req_func,
   // Result output
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_mode,
   output logic             rsp_siren_on,
   output logic             rsp_delay_blink,
   output logic             rsp_alert_valid,
   output logic [2:0]       rsp_alert_source,
   output logic             rsp_reply_valid,
   output logic             rsp_reply_armed,
   // Register writes
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   localparam int LIMIT_W = DELAY_W + $clog2(TICKS_PER_SECOND + 1);

   logic [LIMIT_W-1:0] limit_ff;
   logic [HOLD_W-1:0]  motion_hold_ff;
   logic [HOLD_W-1:0]  shock_hold_ff;
   logic [COUNT_W-1:0] debounce_ff;

   item_type           item_ff;
   logic               item_valid_ff;
   result_type         rsp_ff;
   logic               rsp_valid_ff;
   logic               step;
   logic               csr_write;

   sensor_vec_type     fire;
   sensor_vec_type     scan_en;
   result_type         result;

   // Handshake control
   assign step      = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || step;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register file; entry delay kept as a tick limit
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= LIMIT_W'(ENTRY_DELAY_RST * TICKS_PER_SECOND);
         motion_hold_ff <= MOTION_HOLD_RST;
         shock_hold_ff  <= SHOCK_HOLD_RST;
         debounce_ff    <= DEBOUNCE_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ENTRY_DELAY: limit_ff <= LIMIT_W'(csr_data[DELAY_W-1:0])
                                         * LIMIT_W'(TICKS_PER_SECOND);
            CSR_MOTION_HOLD: motion_hold_ff <= csr_data[HOLD_W-1:0];
            CSR_SHOCK_HOLD:  shock_hold_ff  <= csr_data[HOLD_W-1:0];
            CSR_DEBOUNCE:    debounce_ff    <= csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.motion_a_raw <= req_motion_a_raw;
         item_ff.motion_b_raw <= req_motion_b_raw;
         item_ff.door_raw     <= req_door_raw;
         item_ff.window_raw   <= req_window_raw;
         item_ff.shock_raw    <= req_shock_raw;
         item_ff.tamper_raw   <= req_tamper_raw;
         item_ff.func         <= func_type'(req_func);
      end
   end

   // Sensor qualifiers
   iac_edge_qual u_motion_a (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .enable (scan_en.motion_a),
      .raw    (item_ff.motion_a_raw),
      .hold   (motion_hold_ff),
      .fire   (fire.motion_a)
   );

   iac_edge_qual u_motion_b (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .enable (scan_en.motion_b),
      .raw    (item_ff.motion_b_raw),
      .hold   (motion_hold_ff),
      .fire   (fire.motion_b)
   );

   iac_contact_qual u_door (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .enable   (scan_en.door),
      .raw      (item_ff.door_raw),
      .debounce (debounce_ff),
      .fire     (fire.door)
   );

   iac_contact_qual u_window (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .enable   (scan_en.window),
      .raw      (item_ff.window_raw),
      .debounce (debounce_ff),
      .fire     (fire.window)
   );

   iac_edge_qual u_shock (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .enable (scan_en.shock),
      .raw    (item_ff.shock_raw),
      .hold   (shock_hold_ff),
      .fire   (fire.shock)
   );

   // Mode and timer control
   iac_ctrl #(
      .LIMIT_W (LIMIT_W)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (item_ff),
      .limit   (limit_ff),
      .fire    (fire),
      .scan_en (scan_en),
      .result  (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mode         = rsp_ff.mode;
   assign rsp_siren_on     = rsp_ff.siren_on;
   assign rsp_delay_blink  = rsp_ff.delay_blink;
   assign rsp_alert_valid  = rsp_ff.alert_valid;
   assign rsp_alert_source = rsp_ff.alert_source;
   assign rsp_reply_valid  = rsp_ff.reply_valid;
   assign rsp_reply_armed  = rsp_ff.reply_armed;

endmodule
